/* hdl/mvws_pkg.sv */
`default_nettype none

package mvws_pkg;

	// Fixed field widths
	localparam int DATA_W = 8;
	localparam int ADDR_W = 48;
	localparam int VALUE_W = 64;
	localparam int KIND_W = 3;
	localparam int FILL_W = 3;
	localparam int WIN_DEPTH = 7;
	localparam int CFG_IDX_W = 1;

	// Default wrap width of the address space
	localparam int ADDR_BITS_DEFAULT = 48;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KIND = 1'd1;

	// Older bytes needed in the window, equal to the start address offset
	localparam logic [FILL_W-1:0] NEED_U8 = 3'd0;
	localparam logic [FILL_W-1:0] NEED_U16 = 3'd1;
	localparam logic [FILL_W-1:0] NEED_U32 = 3'd3;
	localparam logic [FILL_W-1:0] NEED_U64 = 3'd7;
	localparam logic [FILL_W-1:0] FILL_MAX = 3'd7;

	// IEEE single masks
	localparam logic [31:0] F32_ABS_MASK = 32'h7FFF_FFFF;
	localparam logic [31:0] F32_INF_BITS = 32'h7F80_0000;

	typedef enum logic [KIND_W-1:0] {
		KIND_U8 = 3'd0,
		KIND_U16 = 3'd1,
		KIND_U32 = 3'd2,
		KIND_U64 = 3'd3,
		KIND_F32 = 3'd4
	} value_kind_t;

	// One classified window, handed from front to back
	typedef struct packed {
		logic [VALUE_W-1:0] cand;
		logic [ADDR_W-1:0] addr;
		logic elig;
	} mvws_entry_t;

	typedef struct packed {
		logic valid;
		mvws_entry_t entry;
	} mvws_push_t;

	typedef struct packed {
		logic valid;
		mvws_entry_t entry;
	} mvws_head_t;

	// IEEE equality: NaN never equal, +0 equals -0
	function automatic logic f32_equal(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ma;
		logic [31:0] mb;
		ma = a & F32_ABS_MASK;
		mb = b & F32_ABS_MASK;
		if (ma > F32_INF_BITS || mb > F32_INF_BITS) begin
			return 1'b0;
		end else if (ma == '0 && mb == '0) begin
			return 1'b1;
		end else begin
			return a == b;
		end
	endfunction

endpackage

`default_nettype wire

/* hdl/mvws_front.sv */
`default_nettype none

module mvws_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [mvws_pkg::DATA_W-1:0]   data_byte,
	input  wire logic [mvws_pkg::ADDR_W-1:0]   byte_address,
	input  wire logic                          region_start,
	input  wire logic [mvws_pkg::KIND_W-1:0]   value_kind,
	input  wire logic                          q_full,
	output mvws_pkg::mvws_push_t               push
);
	import mvws_pkg::*;

	logic [DATA_W-1:0] win_q [WIN_DEPTH];
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_eff;
	logic              accept;
	logic              elig;
	logic [VALUE_W-1:0] cand;
	value_kind_t       kind;

	assign kind = value_kind_t'(value_kind);
	assign in_stall = q_full;
	assign accept = in_valid && !q_full;

	// Drop older bytes at a region start
	assign fill_eff = region_start ? '0 : fill_q;

	// Classify: assemble the candidate and check the region holds enough bytes
	always_comb begin
		elig = 1'b0;
		cand = '0;
		unique case (kind) inside
			KIND_U8: begin
				elig = fill_eff >= NEED_U8;
				cand = {{(VALUE_W-8){1'b0}}, data_byte};
			end
			KIND_U16: begin
				elig = fill_eff >= NEED_U16;
				cand = {{(VALUE_W-16){1'b0}}, data_byte, win_q[0]};
			end
			KIND_U32, KIND_F32: begin
				elig = fill_eff >= NEED_U32;
				cand = {{(VALUE_W-32){1'b0}}, data_byte, win_q[0], win_q[1], win_q[2]};
			end
			KIND_U64: begin
				elig = fill_eff >= NEED_U64;
				cand = {data_byte, win_q[0], win_q[1], win_q[2], win_q[3], win_q[4],
					win_q[5], win_q[6]};
			end
			default: begin
				elig = 1'b0;
				cand = '0;
			end
		endcase
	end

	assign push.valid = accept;
	assign push.entry.cand = cand;
	assign push.entry.addr = byte_address;
	assign push.entry.elig = elig;

	// Advance the window and the fill count on every accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int i = 0; i < WIN_DEPTH; i++) begin
				win_q[i] <= '0;
			end
		end else if (accept) begin
			fill_q <= (fill_eff == FILL_MAX) ? FILL_MAX : fill_eff + 3'd1;
			win_q[0] <= data_byte;
			for (int i = 1; i < WIN_DEPTH; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/mvws_queue.sv */
`default_nettype none

module mvws_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mvws_pkg::mvws_push_t  push,
	output logic                       full,
	output mvws_pkg::mvws_head_t       head,
	input  wire logic                  pop
);
	import mvws_pkg::*;

	mvws_entry_t             slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]  wr_ptr_q;
	logic [QUEUE_PTR_W-1:0]  rd_ptr_q;
	logic [QUEUE_CNT_W-1:0]  count_q;
	logic                    do_push;
	logic                    do_pop;

	assign full = count_q == QUEUE_CNT_W'(QUEUE_DEPTH);
	assign head.valid = count_q != '0;
	assign head.entry = slot_q[rd_ptr_q];
	assign do_push = push.valid && !full;
	assign do_pop = pop && head.valid;

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/mvws_back.sv */
`default_nettype none

module mvws_back #(
	parameter int ADDR_BITS = mvws_pkg::ADDR_BITS_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mvws_pkg::mvws_head_t          head,
	output logic                               pop,
	input  wire logic [mvws_pkg::VALUE_W-1:0]  target_value,
	input  wire logic [mvws_pkg::KIND_W-1:0]   value_kind,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [mvws_pkg::ADDR_W-1:0]        match_address
);
	import mvws_pkg::*;

	localparam int KEEP_BITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - KEEP_BITS);

	logic                 out_valid_q;
	logic [ADDR_W-1:0]    match_address_q;
	logic                 ready;
	logic                 hit;
	logic [FILL_W-1:0]    offset;
	logic [ADDR_W-1:0]    start_addr;
	value_kind_t          kind;

	assign kind = value_kind_t'(value_kind);
	assign ready = !out_valid_q || !out_stall;
	assign pop = head.valid && ready;

	// Compare the candidate with the target at the selected width
	always_comb begin
		hit = 1'b0;
		offset = '0;
		unique case (kind)
			KIND_U8: begin
				hit = head.entry.cand[7:0] == target_value[7:0];
				offset = NEED_U8;
			end
			KIND_U16: begin
				hit = head.entry.cand[15:0] == target_value[15:0];
				offset = NEED_U16;
			end
			KIND_U32: begin
				hit = head.entry.cand[31:0] == target_value[31:0];
				offset = NEED_U32;
			end
			KIND_U64: begin
				hit = head.entry.cand == target_value;
				offset = NEED_U64;
			end
			KIND_F32: begin
				hit = f32_equal(head.entry.cand[31:0], target_value[31:0]);
				offset = NEED_U32;
			end
			default: begin
				hit = 1'b0;
				offset = '0;
			end
		endcase
	end

	// Window start address, wrapped to the address space
	assign start_addr = (head.entry.addr - {{(ADDR_W-FILL_W){1'b0}}, offset}) & ADDR_MASK;

	// Output register: hold a stalled result; otherwise load, setting valid only for an eligible hit on a pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready) begin
			out_valid_q <= pop && head.entry.elig && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.entry.elig && hit) begin
			match_address_q <= start_addr;
		end
	end

	assign out_valid = out_valid_q;
	assign match_address = match_address_q;

endmodule

`default_nettype wire

/* hdl/memory_value_window_scan.sv */
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+------------------------------------------
// input    | in        | in_valid / in_stall | data_byte, byte_address, region_start
// result   | out       | out_valid/out_stall | match_address
// config   | in        | cfg_write           | cfg_index, cfg_data
//
// One byte is taken per clock while in_stall is low; a match passes through the queue and then the output register.
// The four-entry queue between the window front and the compare back sets how long
// the input keeps flowing while results are stalled; in_stall rises only when it fills.
// Reset clears the window, the fill count, the queue and the registers
// (target zero, 8-bit compare); the byte after reset starts a region.

`default_nettype none

module memory_value_window_scan #(
	parameter int ADDR_BITS = mvws_pkg::ADDR_BITS_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [mvws_pkg::DATA_W-1:0]     data_byte,
	input  wire logic [mvws_pkg::ADDR_W-1:0]     byte_address,
	input  wire logic                            region_start,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [mvws_pkg::ADDR_W-1:0]          match_address,
	input  wire logic                            cfg_write,
	input  wire logic [mvws_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mvws_pkg::VALUE_W-1:0]    cfg_data
);
	import mvws_pkg::*;

	logic [VALUE_W-1:0] target_value_q;
	logic [KIND_W-1:0]  value_kind_q;
	mvws_push_t         push;
	mvws_head_t         head;
	logic               q_full;
	logic               pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_value_q <= '0;
			value_kind_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_TARGET: target_value_q <= cfg_data;
				REG_KIND:   value_kind_q <= cfg_data[KIND_W-1:0];
				default: begin
				end
			endcase
		end
	end

	mvws_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.byte_address (byte_address),
		.region_start (region_start),
		.value_kind   (value_kind_q),
		.q_full       (q_full),
		.push         (push)
	);

	mvws_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	mvws_back #(
		.ADDR_BITS (ADDR_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.target_value  (target_value_q),
		.value_kind    (value_kind_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.match_address (match_address)
	);

endmodule

`default_nettype wire

/* hdl/mvws_checker.sv */
`default_nettype none

module mvws_checker #(
	parameter int ADDR_BITS = mvws_pkg::ADDR_BITS_DEFAULT
) (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_stall,
	input wire logic                            out_valid,
	input wire logic                            out_stall,
	input wire logic [mvws_pkg::ADDR_W-1:0]     match_address
);
	import mvws_pkg::*;

	localparam int KEEP_BITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - KEEP_BITS);

	// No result while reset is held
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result shown during reset");

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(match_address))
		else $error("stalled result changed");

	// The queue fills only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> $past(out_valid && out_stall))
		else $error("input stalled without a stalled result");

	// Start addresses stay inside the wrapped address space
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (match_address & ~ADDR_MASK) == '0)
		else $error("match address outside address space");

endmodule

bind memory_value_window_scan mvws_checker #(.ADDR_BITS(ADDR_BITS)) u_mvws_checker (.*);

`default_nettype wire
